// File: hdl/bdd_pkg.sv
// bdd_pkg: shared types, constants and the green interpolation function
// for the directional bayer demosaic core
// no dependencies
package bdd_pkg;

	localparam int PIX_W         = 8;
	localparam int GRN_W         = 10;
	localparam int WIN           = 7;
	localparam int LINES         = 6;
	localparam int DEF_MAX_WIDTH = 4096;
	localparam int MIN_DIM       = 12;
	localparam int WIDTH_W       = 13;
	localparam int HEIGHT_W      = 16;
	localparam int COL_W         = 12;
	localparam int ROW_W         = 16;
	localparam int APB_AW        = 4;
	localparam int APB_DW        = 32;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_PHASE  = 2'd2
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_t;
	typedef logic signed [GRN_W-1:0] grn_t;

	typedef struct packed {
		logic [WIDTH_W-1:0]  width;
		logic [HEIGHT_W-1:0] height;
		logic [1:0]          phase;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic             emit;
		logic             rpar;
		logic             cpar;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} meta_t;

	typedef struct packed {
		pix_t             red;
		pix_t             green;
		pix_t             blue;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} rgb_t;

	function automatic logic signed [11:0] s12(input pix_t p);
		return $signed({4'b0, p});
	endfunction

	function automatic logic signed [11:0] abs12(input logic signed [11:0] v);
		return (v < 0) ? -v : v;
	endfunction

	// one direction: half-sum estimate plus quarter second-derivative correction
	function automatic logic signed [11:0] dir_est(input pix_t vc, input pix_t m1,
			input pix_t p1, input pix_t m2, input pix_t p2);
		logic [9:0]          e;
		logic [9:0]          a;
		logic signed [11:0]  t;
		e = ({2'b0, m1} + {2'b0, p1} + 10'd1) >> 1;
		a = ({2'b0, m2} + {2'b0, p2} + 10'd1) >> 1;
		t = s12(vc) - $signed({2'b0, a}) + 12'sd1;
		return $signed({2'b0, e}) + (t >>> 1);
	endfunction

	function automatic grn_t green_fn(input logic rb, input pix_t vc,
			input pix_t xm1, input pix_t xp1, input pix_t xm2, input pix_t xp2,
			input pix_t ym1, input pix_t yp1, input pix_t ym2, input pix_t yp2);
		logic signed [11:0] gh;
		logic signed [11:0] gv;
		logic [9:0]         eh;
		logic [9:0]         ev;
		logic [9:0]         avg;
		logic signed [11:0] res;
		gh  = abs12(s12(xm1) - s12(xp1)) + abs12((s12(vc) <<< 1) - s12(xm2) - s12(xp2));
		gv  = abs12(s12(ym1) - s12(yp1)) + abs12((s12(vc) <<< 1) - s12(ym2) - s12(yp2));
		eh  = ({2'b0, xm1} + {2'b0, xp1} + 10'd1) >> 1;
		ev  = ({2'b0, ym1} + {2'b0, yp1} + 10'd1) >> 1;
		avg = (eh + ev + 10'd1) >> 1;
		if (!rb) begin
			res = s12(vc);
		end else if (gh < gv) begin
			res = dir_est(vc, xm1, xp1, xm2, xp2);
		end else if (gv < gh) begin
			res = dir_est(vc, ym1, yp1, ym2, yp2);
		end else begin
			res = $signed({2'b0, avg});
		end
		return res[GRN_W-1:0];
	endfunction

endpackage

// File: hdl/bdd_in_if.sv
// bdd_in_if: raw pixel channel, valid/ready with payload
// depends on bdd_pkg
interface bdd_in_if;
	logic                  valid;
	logic                  ready;
	logic [bdd_pkg::PIX_W-1:0] raw_pixel;
	logic                  frame_start;

	modport source (output valid, output raw_pixel, output frame_start, input ready);
	modport sink   (input valid, input raw_pixel, input frame_start, output ready);
endinterface

// File: hdl/bdd_out_if.sv
// bdd_out_if: rgb result channel, valid/ready with payload
// depends on bdd_pkg
interface bdd_out_if;
	logic                       valid;
	logic                       ready;
	logic [bdd_pkg::PIX_W-1:0]  red;
	logic [bdd_pkg::PIX_W-1:0]  green;
	logic [bdd_pkg::PIX_W-1:0]  blue;
	logic [bdd_pkg::COL_W-1:0]  out_col;
	logic [bdd_pkg::ROW_W-1:0]  out_row;
	logic                       frame_last;

	modport source (output valid, output red, output green, output blue, output out_col,
		output out_row, output frame_last, input ready);
	modport sink   (input valid, input red, input green, input blue, input out_col,
		input out_row, input frame_last, output ready);
endinterface

// File: hdl/bdd_cfg_regs.sv
// bdd_cfg_regs: apb register file for geometry and mosaic phase
// depends on bdd_pkg
module bdd_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bdd_pkg::APB_AW-1:0]  paddr,
	input  logic [bdd_pkg::APB_DW-1:0]  pwdata,
	output logic [bdd_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output bdd_pkg::cfg_t               cfg
);
	import bdd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= WIDTH_W'(640);
			cfg_q.height <= HEIGHT_W'(480);
			cfg_q.phase  <= 2'd0;
		end else if (wr) begin
			unique case (idx)
				REG_WIDTH:  cfg_q.width  <= pwdata[WIDTH_W-1:0];
				REG_HEIGHT: cfg_q.height <= pwdata[HEIGHT_W-1:0];
				REG_PHASE:  cfg_q.phase  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = APB_DW'(cfg_q.width);
			REG_HEIGHT: prdata = APB_DW'(cfg_q.height);
			REG_PHASE:  prdata = APB_DW'(cfg_q.phase);
			default:    prdata = '0;
		endcase
	end
endmodule

// File: hdl/bdd_line_store.sv
// bdd_line_store: position counters, six-line column memory with
// read-modify-write and forwarding, and the 7x7 sample window
// depends on bdd_pkg
module bdd_line_store #(
	parameter int MAX_WIDTH = bdd_pkg::DEF_MAX_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       fire,
	input  logic [bdd_pkg::PIX_W-1:0]  px,
	input  logic                       frame_start,
	input  bdd_pkg::cfg_t              cfg,
	output bdd_pkg::win_t              win,
	output bdd_pkg::meta_t             meta_s2
);
	import bdd_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int MW = LINES * PIX_W;

	logic [MW-1:0]     mem [MAX_WIDTH];
	logic [MW-1:0]     rd_q;
	logic [MW-1:0]     byp_q;
	logic              byp_hit_q;
	logic [MW-1:0]     colv;
	logic [MW-1:0]     newcol;
	logic [AW-1:0]     addr_s1;
	pix_t              px_s1;
	meta_t             s1_q;
	meta_t             s2_q;
	meta_t             s0;
	win_t              win_q;

	logic [CW-1:0]       col_q;
	logic [ROW_W-1:0]    row_q;
	logic [CW-1:0]       w;
	logic [ROW_W-1:0]    h;
	logic [CW-1:0]       c;
	logic [ROW_W-1:0]    r;
	logic [CW:0]         c1;
	logic [ROW_W:0]      r1;
	logic [31:0]         col_m3;
	logic [ROW_W-1:0]    row_m3;

	// effective geometry
	always_comb begin
		if (cfg.width < WIDTH_W'(MIN_DIM)) begin
			w = CW'(MIN_DIM);
		end else if (32'(cfg.width) > 32'(MAX_WIDTH)) begin
			w = CW'(MAX_WIDTH);
		end else begin
			w = CW'(cfg.width);
		end
		h = (cfg.height < HEIGHT_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : cfg.height;
	end

	assign c      = frame_start ? '0 : col_q;
	assign r      = frame_start ? '0 : row_q;
	assign c1     = {1'b0, c} + 1'b1;
	assign r1     = {1'b0, r} + 1'b1;
	assign col_m3 = 32'(c) - 32'd3;
	assign row_m3 = r - ROW_W'(3);

	always_comb begin
		s0.valid = 1'b1;
		s0.emit  = (c >= CW'(6)) && (c < w) && (r >= ROW_W'(6)) && (r < h);
		s0.rpar  = r[0];
		s0.cpar  = c[0];
		s0.col   = col_m3[COL_W-1:0];
		s0.row   = row_m3;
		s0.last  = (c == w - 1'b1) && (r == h - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (fire) begin
			if (c1 >= {1'b0, w}) begin
				col_q <= '0;
				row_q <= (r1 >= {1'b0, h}) ? '0 : r1[ROW_W-1:0];
			end else begin
				col_q <= c1[CW-1:0];
				row_q <= r;
			end
		end
	end

	// column read at accept, shifted column written back from the registered read in the write stage
	assign colv   = byp_hit_q ? byp_q : rd_q;
	assign newcol = {px_s1, colv[MW-1:PIX_W]};

	always_ff @(posedge clk) begin
		if (fire) begin
			rd_q    <= mem[c[AW-1:0]];
			addr_s1 <= c[AW-1:0];
			px_s1   <= px;
		end
		if (en && s1_q.valid) begin
			mem[addr_s1] <= newcol;
		end
		if (en) begin
			byp_q <= newcol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q      <= '0;
			s2_q      <= '0;
			byp_hit_q <= 1'b0;
		end else if (en) begin
			s1_q      <= fire ? s0 : '0;
			s2_q      <= s1_q;
			byp_hit_q <= fire && s1_q.valid && (c[AW-1:0] == addr_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (en && s1_q.valid) begin
			for (int i = 0; i < WIN; i++) begin
				for (int j = 0; j < WIN - 1; j++) begin
					win_q[i][j] <= win_q[i][j+1];
				end
			end
			for (int k = 0; k < LINES; k++) begin
				win_q[k][WIN-1] <= colv[k*PIX_W +: PIX_W];
			end
			win_q[WIN-1][WIN-1] <= px_s1;
		end
	end

	assign win     = win_q;
	assign meta_s2 = s2_q;

	a_byp_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		byp_hit_q |-> s1_q.valid)
		else $error("forwarding flagged without an item in the write stage");
	a_fire_en: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> s1_q.valid)
		else $error("accepted beat did not reach the write stage");
endmodule

// File: hdl/bdd_interp.sv
// bdd_interp: directional green at the 3x3 core of the window, then
// color-difference red and blue with clamping
// depends on bdd_pkg
module bdd_interp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [1:0]      phase,
	input  bdd_pkg::win_t   win,
	input  bdd_pkg::meta_t  meta_s2,
	output logic            res_valid,
	output bdd_pkg::rgb_t   res
);
	import bdd_pkg::*;

	grn_t   g2 [3][3];
	grn_t   g_s3 [3][3];
	pix_t   raw_s3 [3][3];
	logic   ctr_rb_s3;
	logic   ctr_red_s3;
	logic   hv_red_s3;
	meta_t  meta_s3;
	logic   ry;
	logic   rx;

	assign ry = phase[0];
	assign rx = phase[0] ^ phase[1];

	for (genvar di = 0; di < 3; di++) begin : g_row
		for (genvar dj = 0; dj < 3; dj++) begin : g_col
			localparam int I = di + 2;
			localparam int J = dj + 2;
			logic rp, cp, rb;
			assign rp = meta_s2.rpar ^ I[0];
			assign cp = meta_s2.cpar ^ J[0];
			assign rb = ((rp == ry) && (cp == rx)) || ((rp != ry) && (cp != rx));
			assign g2[di][dj] = green_fn(rb, win[I][J],
				win[I][J-1], win[I][J+1], win[I][J-2], win[I][J+2],
				win[I-1][J], win[I+1][J], win[I-2][J], win[I+2][J]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					g_s3[i][j]   <= g2[i][j];
					raw_s3[i][j] <= win[i+2][j+2];
				end
			end
			// center (3,3): row parity rpar^1, column parity cpar^1
			ctr_red_s3 <= ((meta_s2.rpar ^ 1'b1) == ry) && ((meta_s2.cpar ^ 1'b1) == rx);
			ctr_rb_s3  <= (((meta_s2.rpar ^ 1'b1) == ry) && ((meta_s2.cpar ^ 1'b1) == rx))
				|| (((meta_s2.rpar ^ 1'b1) != ry) && ((meta_s2.cpar ^ 1'b1) != rx));
			// side neighbor (3,2) is red: row parity matches, column parity cpar
			hv_red_s3  <= ((meta_s2.rpar ^ 1'b1) == ry) && (meta_s2.cpar == rx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s3 <= '0;
		end else if (en) begin
			meta_s3 <= meta_s2;
		end
	end

	function automatic logic signed [13:0] cd(input pix_t p, input grn_t g);
		return $signed({6'b0, p}) - 14'(g);
	endfunction

	function automatic logic signed [13:0] tdiv(input logic signed [13:0] x,
			input int unsigned sh);
		logic signed [13:0] n;
		n = -x;
		return (x < 0) ? -(n >>> sh) : (x >>> sh);
	endfunction

	function automatic pix_t clamp8(input logic signed [13:0] v);
		return (v < 0) ? '0 : ((v > 14'sd255) ? 8'd255 : v[7:0]);
	endfunction

	logic signed [13:0] gc;
	logic signed [13:0] dsum;
	logic signed [13:0] hsum;
	logic signed [13:0] vsum;
	logic signed [13:0] rv;
	logic signed [13:0] bv;

	always_comb begin
		gc   = 14'(g_s3[1][1]);
		dsum = cd(raw_s3[0][0], g_s3[0][0]) + cd(raw_s3[0][2], g_s3[0][2])
			+ cd(raw_s3[2][0], g_s3[2][0]) + cd(raw_s3[2][2], g_s3[2][2]);
		hsum = cd(raw_s3[1][0], g_s3[1][0]) + cd(raw_s3[1][2], g_s3[1][2]);
		vsum = cd(raw_s3[0][1], g_s3[0][1]) + cd(raw_s3[2][1], g_s3[2][1]);
		if (ctr_rb_s3) begin
			if (ctr_red_s3) begin
				rv = $signed({6'b0, raw_s3[1][1]});
				bv = gc + tdiv(dsum + 14'sd2, 2);
			end else begin
				bv = $signed({6'b0, raw_s3[1][1]});
				rv = gc + tdiv(dsum + 14'sd2, 2);
			end
		end else if (hv_red_s3) begin
			rv = gc + tdiv(hsum + 14'sd1, 1);
			bv = gc + tdiv(vsum + 14'sd1, 1);
		end else begin
			rv = gc + tdiv(vsum + 14'sd1, 1);
			bv = gc + tdiv(hsum + 14'sd1, 1);
		end
		res.red   = clamp8(rv);
		res.green = clamp8(gc);
		res.blue  = clamp8(bv);
		res.col   = meta_s3.col;
		res.row   = meta_s3.row;
		res.last  = meta_s3.last;
	end

	assign res_valid = meta_s3.valid && meta_s3.emit;
endmodule

// File: hdl/bdd_out_queue.sv
// bdd_out_queue: two-entry result queue that decouples the pipeline
// from the output handshake
// depends on bdd_pkg
module bdd_out_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bdd_pkg::rgb_t   din,
	output logic            room,
	output logic            dout_valid,
	input  logic            dout_ready,
	output bdd_pkg::rgb_t   dout
);
	import bdd_pkg::*;

	rgb_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop        = dout_valid && dout_ready;
	assign dout_valid = (cnt_q != 2'd0);
	assign dout       = ent_q[rp_q];
	assign room       = (cnt_q != 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && (cnt_q == 2'd2)))
		else $error("result pushed into full queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");
	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("queue count did not drop after a pop");
endmodule

// File: hdl/bayer_directional_demosaic_core.sv
// bayer_directional_demosaic_core: streaming bayer to rgb with directional green
// a result leaves after the beat of sample (x+3, y+3) via write stage, window, stage 3 and queue; throughput
// one beat per cycle while the queue has room, set by the single line memory column read-modify-write per beat
// reset: arst_n clears counters, pipeline valids, queue and registers (640x480, rggb);
// line memory contents are not cleared, rows are written before they are read
module bayer_directional_demosaic_core #(
	parameter int MAX_WIDTH = bdd_pkg::DEF_MAX_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bdd_pkg::APB_AW-1:0]  paddr,
	input  logic [bdd_pkg::APB_DW-1:0]  pwdata,
	output logic [bdd_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	bdd_in_if.sink                      pix_in,
	bdd_out_if.source                   rgb_out
);
	import bdd_pkg::*;

	cfg_t   cfg;
	win_t   win;
	meta_t  meta_s2;
	rgb_t   res;
	rgb_t   qout;
	logic   res_valid;
	logic   room;
	logic   en;
	logic   fire;

	// whole pipeline moves together whenever the queue has a free slot;
	// a result may wait in the queue while new beats keep coming
	assign en           = room;
	assign pix_in.ready = en;
	assign fire         = pix_in.valid && en;

	bdd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage 0 accept and column read, stage 1 write-back and window shift
	bdd_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_lines (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.fire        (fire),
		.px          (pix_in.raw_pixel),
		.frame_start (pix_in.frame_start),
		.cfg         (cfg),
		.win         (win),
		.meta_s2     (meta_s2)
	);

	// stage 2 green estimates, stage 3 red/blue and clamp
	bdd_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.phase     (cfg.phase),
		.win       (win),
		.meta_s2   (meta_s2),
		.res_valid (res_valid),
		.res       (res)
	);

	bdd_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (en && res_valid),
		.din        (res),
		.room       (room),
		.dout_valid (rgb_out.valid),
		.dout_ready (rgb_out.ready),
		.dout       (qout)
	);

	assign rgb_out.red        = qout.red;
	assign rgb_out.green      = qout.green;
	assign rgb_out.blue       = qout.blue;
	assign rgb_out.out_col    = qout.col;
	assign rgb_out.out_row    = qout.row;
	assign rgb_out.frame_last = qout.last;
endmodule
